// File: hdl/h264sps_pkg.sv
package h264sps_pkg;

  localparam int unsigned MaxLeadZerosDef = 31;
  localparam int unsigned DimBitsDef      = 16;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned DimW    = 16;
  localparam int unsigned RateW   = 32;
  localparam int unsigned FieldW  = 32;
  localparam int unsigned CodeW   = 33;
  localparam int unsigned BitCntW = 6;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOT_SPS = 2'd1,
    STAT_SHORT   = 2'd2,
    STAT_EG_OVF  = 2'd3
  } status_e;

  localparam logic [4:0]       NalTypeSps = 5'd7;
  localparam logic [7:0]       ScaleInit  = 8'd8;
  localparam logic [7:0]       AspectExt  = 8'd255;
  localparam logic [ByteW-1:0] EpbByte    = 8'h03;

endpackage

// File: hdl/h264sps_if.sv
interface h264sps_in_if;
  import h264sps_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface h264sps_out_if;
  import h264sps_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [7:0]       profile;
  logic [7:0]       level;
  logic [1:0]       chroma_format;
  logic [DimW-1:0]  frame_width;
  logic [DimW-1:0]  frame_height;
  logic [RateW-1:0] frame_rate;
  modport source (output valid, status, profile, level, chroma_format, frame_width,
                  frame_height, frame_rate, input ready);
  modport sink   (input valid, status, profile, level, chroma_format, frame_width,
                  frame_height, frame_rate, output ready);
endinterface

// File: hdl/h264_sps_header_parser.sv
// The single bit-serial syntax unit takes a word only in idle, works its eight bits in the
// bit state, then wraps up; a dropped 0x03 goes from accept straight to wrap-up. The word
// ending the parse loads the result register in a send state, held while output stalls;
// for the frame rate a restoring divider runs first (one quotient bit a cycle).
// Reset (async, active low) clears the parser to expect a NAL header byte, no result.
module h264_sps_header_parser #(
  parameter int unsigned MAX_LEAD_ZEROS = h264sps_pkg::MaxLeadZerosDef,
  parameter int unsigned DIM_BITS       = h264sps_pkg::DimBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  h264sps_in_if.sink    in_i,
  h264sps_out_if.source out_o
);
  import h264sps_pkg::*;

  localparam int unsigned LzW = $clog2(MAX_LEAD_ZEROS + 2);
  localparam logic [39:0] DimLim = 40'((64'd1 << DIM_BITS) - 64'd1);

  // Top-level sequencer
  typedef enum logic [2:0] {ST_IDLE, ST_BITS, ST_DIV, ST_END, ST_SEND} state_e;

  // Syntax element being read
  typedef enum logic [5:0] {
    S_HDR, S_PROFILE, S_CONSTR, S_LEVEL, S_SPSID, S_CHROMA, S_SEPCOL, S_BDL,
    S_BDC, S_QPBYPASS, S_SMPRESENT, S_SLFLAG, S_SLDELTA, S_LOG2FN, S_POCTYPE,
    S_POCLSB, S_POCZERO, S_OFFNR, S_OFFTB, S_NUMREF, S_OFFREF, S_MAXREF,
    S_GAPS, S_WIDTH, S_HEIGHT, S_FMO, S_MBAFF, S_D8X8, S_CROPF, S_CROPL,
    S_CROPR, S_CROPT, S_CROPB, S_VUIF, S_ARF, S_ARIDC, S_SAR, S_OVF, S_OVA,
    S_VSF, S_VFMT, S_COLOR, S_CLOC, S_CLTOP, S_CLBOT, S_TIMF, S_NUIT,
    S_TSCALE, S_FIXED, S_SKIP
  } step_e;

  // Next read: target step, exp-Golomb or fixed, fixed length
  typedef struct packed {
    step_e              step;
    logic               ue;
    logic [BitCntW-1:0] n;
  } rd_t;

  function automatic rd_t rdf(step_e s, logic [BitCntW-1:0] n);
    rd_t r;
    r.step = s;
    r.ue   = 1'b0;
    r.n    = n;
    return r;
  endfunction

  function automatic rd_t rdc(step_e s);
    rd_t r;
    r.step = s;
    r.ue   = 1'b1;
    r.n    = '0;
    return r;
  endfunction

  function automatic logic high_profile(logic [7:0] p);
    return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244 || p == 8'd44 ||
           p == 8'd83  || p == 8'd86  || p == 8'd118 || p == 8'd128 || p == 8'd138 ||
           p == 8'd139 || p == 8'd134 || p == 8'd135;
  endfunction

  state_e             state_q, state_d;
  step_e              step_q, step_d;
  logic [1:0]         zrun_q, zrun_d;
  logic [ByteW-1:0]   shift_q, shift_d;
  logic [2:0]         bcnt_q, bcnt_d;
  logic               last_q, last_d;
  logic               rd_ue_q, rd_ue_d;
  logic               suffix_q, suffix_d;
  logic [BitCntW-1:0] bits_left_q, bits_left_d;
  logic [LzW-1:0]     lead_q, lead_d;
  logic [CodeW-1:0]   code_q, code_d;
  logic [6:0]         loop_q, loop_d;
  logic [7:0]         sc0_q, sc0_d, sc1_q, sc1_d;
  logic [3:0]         list_q, list_d;
  logic [7:0]         prof_q, prof_d, lvl_q, lvl_d, chroma_q, chroma_d;
  logic               fmo_q, fmo_d;
  logic [FieldW-1:0]  wid_q, wid_d, hgt_q, hgt_d, nref_q, nref_d;
  // crop left/right/top/bottom; entries 0 and 1 later hold tick units and time scale
  logic [FieldW-1:0]  crop_q [4];
  logic [FieldW-1:0]  crop_d [4];
  logic               have_res_q, have_res_d;
  status_e            status_q, status_d;
  logic               fixed_q, fixed_d;
  logic [FieldW:0]    rem_q, rem_d;
  logic [RateW-1:0]   quo_q, quo_d;
  logic [4:0]         dcnt_q, dcnt_d;

  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [7:0]         out_prof_q, out_lvl_q;
  logic [1:0]         out_chroma_q;
  logic [DimW-1:0]    out_wid_q, out_hgt_q;
  logic [RateW-1:0]   out_rate_q;
  logic               load_out;

  // bit-level scratch
  logic               cur_bit;
  logic [CodeW-1:0]   code_n, lead_mask, ev;
  logic [FieldW-1:0]  ex;
  logic [BitCntW-1:0] bl_n;
  logic               elem_fire, rd_new, fin, go_div;
  status_e            fin_st;
  rd_t                rd;
  // scaling list helpers
  logic [3:0]         nl_idx;
  logic               nl_more;
  logic [8:0]         dpos;
  logic [7:0]         d8, s1n;
  logic [6:0]         loop_n;
  logic [FieldW-1:0]  nref_m;
  // cropped dimensions
  logic [39:0]        w_full, h_full, cw, ch, w_cut, h_cut, dim_w, dim_h;
  // divider step
  logic [FieldW:0]    rem_t;
  logic               ge;
  logic [RateW-1:0]   qn;

  assign cur_bit   = shift_q[ByteW-1];
  assign lead_mask = (CodeW'(1) << lead_q) - CodeW'(1);
  assign nl_idx    = list_q + 4'd1;
  assign nl_more   = nl_idx < ((chroma_q == 8'd3) ? 4'd12 : 4'd8);
  assign ex        = ev[FieldW-1:0];

  // signed scaling delta, only its low byte matters
  assign dpos   = ev[8:0] + 9'd1;
  assign d8     = ev[0] ? dpos[8:1] : (8'd0 - ev[8:1]);
  assign s1n    = sc0_q + d8;
  assign loop_n = loop_q + 7'd1;
  assign nref_m = nref_q - 32'd1;

  // cropped frame size, saturated both ways
  always_comb begin
    w_full = ({8'd0, wid_q} + 40'd1) << 4;
    h_full = fmo_q ? (({8'd0, hgt_q} + 40'd1) << 4) : (({8'd0, hgt_q} + 40'd1) << 5);
    cw = {8'd0, crop_q[0]} + {8'd0, crop_q[1]};
    ch = {8'd0, crop_q[2]} + {8'd0, crop_q[3]};
    if (chroma_q == 8'd1 || chroma_q == 8'd2) begin
      cw = cw << 1;
    end
    if (chroma_q == 8'd1) begin
      ch = fmo_q ? (ch << 1) : (ch << 2);
    end else if (!fmo_q) begin
      ch = ch << 1;
    end
    w_cut = (w_full > cw) ? (w_full - cw) : '0;
    h_cut = (h_full > ch) ? (h_full - ch) : '0;
    dim_w = (w_cut > DimLim) ? DimLim : w_cut;
    dim_h = (h_cut > DimLim) ? DimLim : h_cut;
  end

  // restoring divider step: time scale over tick units
  assign rem_t = {rem_q[FieldW-1:0], quo_q[RateW-1]};
  assign ge    = rem_t >= {1'b0, crop_q[0]};
  assign qn    = {quo_q[RateW-2:0], ge};

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    zrun_d      = zrun_q;
    shift_d     = shift_q;
    bcnt_d      = bcnt_q;
    last_d      = last_q;
    rd_ue_d     = rd_ue_q;
    suffix_d    = suffix_q;
    bits_left_d = bits_left_q;
    lead_d      = lead_q;
    code_d      = code_q;
    loop_d      = loop_q;
    sc0_d       = sc0_q;
    sc1_d       = sc1_q;
    list_d      = list_q;
    prof_d      = prof_q;
    lvl_d       = lvl_q;
    chroma_d    = chroma_q;
    fmo_d       = fmo_q;
    wid_d       = wid_q;
    hgt_d       = hgt_q;
    nref_d      = nref_q;
    crop_d      = crop_q;
    have_res_d  = have_res_q;
    status_d    = status_q;
    fixed_d     = fixed_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dcnt_d      = dcnt_q;
    load_out    = 1'b0;
    code_n      = '0;
    bl_n        = '0;
    ev          = '0;
    elem_fire   = 1'b0;
    rd_new      = 1'b0;
    fin         = 1'b0;
    go_div      = 1'b0;
    fin_st      = STAT_OK;
    rd          = rdf(S_HDR, 6'd8);

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          shift_d    = in_i.data_byte;
          last_d     = in_i.last_byte;
          have_res_d = 1'b0;
          bcnt_d     = '0;
          if (zrun_q == 2'd2 && in_i.data_byte == EpbByte) begin
            zrun_d  = '0;  // emulation prevention byte: drop it
            state_d = ST_END;
          end else begin
            if (in_i.data_byte == '0) begin
              zrun_d = (zrun_q == 2'd2) ? 2'd2 : zrun_q + 2'd1;
            end else begin
              zrun_d = '0;
            end
            state_d = ST_BITS;
          end
        end
      end
      ST_BITS: begin
        shift_d = {shift_q[ByteW-2:0], 1'b0};
        bcnt_d  = bcnt_q + 3'd1;
        state_d = (bcnt_q == 3'd7) ? ST_END : ST_BITS;
        if (step_q != S_SKIP) begin
          if (!rd_ue_q || suffix_q) begin
            code_n      = {code_q[CodeW-2:0], cur_bit};
            code_d      = code_n;
            bl_n        = (bits_left_q != '0) ? bits_left_q - 6'd1 : '0;
            bits_left_d = bl_n;
            if (bl_n == '0) begin
              elem_fire = 1'b1;
              ev        = rd_ue_q ? (lead_mask + code_n) : code_n;
            end
          end else if (!cur_bit) begin
            lead_d = lead_q + 1'b1;
            if (({1'b0, lead_q} + 1'b1) > (LzW+1)'(MAX_LEAD_ZEROS)) begin
              fin    = 1'b1;
              fin_st = STAT_EG_OVF;
            end
          end else if (lead_q == '0) begin
            elem_fire = 1'b1;
          end else begin
            suffix_d    = 1'b1;
            bits_left_d = BitCntW'(lead_q);
            code_d      = '0;
          end
        end
      end
      ST_DIV: begin
        rem_d  = ge ? (rem_t - {1'b0, crop_q[0]}) : rem_t;
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd31) begin
          quo_d   = fixed_q ? (qn >> 1) : qn;
          state_d = ST_END;
        end else begin
          quo_d = qn;
        end
      end
      ST_END: begin
        if (last_q) begin
          if (step_q != S_SKIP) begin
            status_d   = STAT_SHORT;  // NAL ended mid-parse
            have_res_d = 1'b1;
            quo_d      = '0;
          end
          zrun_d      = '0;
          step_d      = S_HDR;
          rd_ue_d     = 1'b0;
          bits_left_d = 6'd8;
          code_d      = '0;
        end
        state_d = (have_res_q || (last_q && step_q != S_SKIP)) ? ST_SEND : ST_IDLE;
      end
      ST_SEND: begin
        if (!out_valid_q || out_o.ready) begin
          load_out   = 1'b1;
          have_res_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (elem_fire) begin
      rd_new = 1'b1;
      unique case (step_q)
        S_HDR: begin
          if (ex[4:0] != NalTypeSps) begin
            rd_new = 1'b0;
            fin    = 1'b1;
            fin_st = STAT_NOT_SPS;
          end else begin
            rd = rdf(S_PROFILE, 6'd8);
          end
        end
        S_PROFILE: begin
          prof_d   = ex[7:0];
          lvl_d    = '0;
          chroma_d = '0;
          fmo_d    = 1'b0;
          rd       = rdf(S_CONSTR, 6'd8);
        end
        S_CONSTR: rd = rdf(S_LEVEL, 6'd8);
        S_LEVEL: begin
          lvl_d = ex[7:0];
          rd    = rdc(S_SPSID);
        end
        S_SPSID: begin
          if (high_profile(prof_q)) begin
            rd = rdc(S_CHROMA);
          end else begin
            chroma_d = 8'd1;
            rd       = rdc(S_LOG2FN);
          end
        end
        S_CHROMA: begin
          chroma_d = (ex[FieldW-1:8] != '0) ? 8'd255 : ex[7:0];
          rd       = (ex == 32'd3) ? rdf(S_SEPCOL, 6'd1) : rdc(S_BDL);
        end
        S_SEPCOL:    rd = rdc(S_BDL);
        S_BDL:       rd = rdc(S_BDC);
        S_BDC:       rd = rdf(S_QPBYPASS, 6'd1);
        S_QPBYPASS:  rd = rdf(S_SMPRESENT, 6'd1);
        S_SMPRESENT: begin
          if (ex[0]) begin
            list_d = '0;
            rd     = rdf(S_SLFLAG, 6'd1);
          end else begin
            rd = rdc(S_LOG2FN);
          end
        end
        S_SLFLAG: begin
          if (ex[0]) begin
            // list present: first delta always follows
            sc0_d  = ScaleInit;
            sc1_d  = ScaleInit;
            loop_d = '0;
            rd     = rdc(S_SLDELTA);
          end else begin
            list_d = nl_idx;
            rd     = nl_more ? rdf(S_SLFLAG, 6'd1) : rdc(S_LOG2FN);
          end
        end
        S_SLDELTA: begin
          sc1_d  = s1n;
          if (s1n != '0) begin
            sc0_d = s1n;
          end
          loop_d = loop_n;
          if (loop_n < ((list_q < 4'd6) ? 7'd16 : 7'd64) && s1n != '0) begin
            rd = rdc(S_SLDELTA);
          end else begin
            list_d = nl_idx;
            rd     = nl_more ? rdf(S_SLFLAG, 6'd1) : rdc(S_LOG2FN);
          end
        end
        S_LOG2FN: rd = rdc(S_POCTYPE);
        S_POCTYPE: begin
          if (ex == '0) begin
            rd = rdc(S_POCLSB);
          end else if (ex == 32'd1) begin
            rd = rdf(S_POCZERO, 6'd1);
          end else begin
            rd = rdc(S_MAXREF);
          end
        end
        S_POCLSB:  rd = rdc(S_MAXREF);
        S_POCZERO: rd = rdc(S_OFFNR);
        S_OFFNR:   rd = rdc(S_OFFTB);
        S_OFFTB:   rd = rdc(S_NUMREF);
        S_NUMREF: begin
          nref_d = ex;
          rd     = (ex == '0) ? rdc(S_MAXREF) : rdc(S_OFFREF);
        end
        S_OFFREF: begin
          nref_d = nref_m;
          rd     = (nref_m == '0) ? rdc(S_MAXREF) : rdc(S_OFFREF);
        end
        S_MAXREF: rd = rdf(S_GAPS, 6'd1);
        S_GAPS:   rd = rdc(S_WIDTH);
        S_WIDTH: begin
          wid_d = ex;
          rd    = rdc(S_HEIGHT);
        end
        S_HEIGHT: begin
          hgt_d = ex;
          rd    = rdf(S_FMO, 6'd1);
        end
        S_FMO: begin
          fmo_d = ex[0];
          rd    = ex[0] ? rdf(S_D8X8, 6'd1) : rdf(S_MBAFF, 6'd1);
        end
        S_MBAFF: rd = rdf(S_D8X8, 6'd1);
        S_D8X8:  rd = rdf(S_CROPF, 6'd1);
        S_CROPF: begin
          crop_d[0] = '0;
          crop_d[1] = '0;
          crop_d[2] = '0;
          crop_d[3] = '0;
          rd        = ex[0] ? rdc(S_CROPL) : rdf(S_VUIF, 6'd1);
        end
        S_CROPL: begin
          crop_d[0] = ex;
          rd        = rdc(S_CROPR);
        end
        S_CROPR: begin
          crop_d[1] = ex;
          rd        = rdc(S_CROPT);
        end
        S_CROPT: begin
          crop_d[2] = ex;
          rd        = rdc(S_CROPB);
        end
        S_CROPB: begin
          crop_d[3] = ex;
          rd        = rdf(S_VUIF, 6'd1);
        end
        S_VUIF: begin
          wid_d = FieldW'(dim_w);
          hgt_d = FieldW'(dim_h);
          if (ex[0]) begin
            rd = rdf(S_ARF, 6'd1);
          end else begin
            rd_new = 1'b0;
            fin    = 1'b1;
          end
        end
        S_ARF:   rd = ex[0] ? rdf(S_ARIDC, 6'd8) : rdf(S_OVF, 6'd1);
        S_ARIDC: rd = (ex == {24'd0, AspectExt}) ? rdf(S_SAR, 6'd32) : rdf(S_OVF, 6'd1);
        S_SAR:   rd = rdf(S_OVF, 6'd1);
        S_OVF:   rd = ex[0] ? rdf(S_OVA, 6'd1) : rdf(S_VSF, 6'd1);
        S_OVA:   rd = rdf(S_VSF, 6'd1);
        S_VSF:   rd = ex[0] ? rdf(S_VFMT, 6'd5) : rdf(S_CLOC, 6'd1);
        S_VFMT:  rd = ex[0] ? rdf(S_COLOR, 6'd24) : rdf(S_CLOC, 6'd1);
        S_COLOR: rd = rdf(S_CLOC, 6'd1);
        S_CLOC:  rd = ex[0] ? rdc(S_CLTOP) : rdf(S_TIMF, 6'd1);
        S_CLTOP: rd = rdc(S_CLBOT);
        S_CLBOT: rd = rdf(S_TIMF, 6'd1);
        S_TIMF: begin
          if (ex[0]) begin
            rd = rdf(S_NUIT, 6'd32);
          end else begin
            rd_new = 1'b0;
            fin    = 1'b1;
          end
        end
        S_NUIT: begin
          crop_d[0] = ex;
          rd        = rdf(S_TSCALE, 6'd32);
        end
        S_TSCALE: begin
          crop_d[1] = ex;
          rd        = rdf(S_FIXED, 6'd1);
        end
        S_FIXED: begin
          rd_new  = 1'b0;
          fixed_d = ex[0];
          if (crop_q[0] == '0) begin
            fin = 1'b1;  // zero tick units: rate 0
          end else begin
            go_div = 1'b1;
          end
        end
        default: begin
          rd_new = 1'b0;
          step_d = S_SKIP;
        end
      endcase
    end

    if (fin) begin
      status_d   = fin_st;
      have_res_d = 1'b1;
      step_d     = S_SKIP;
      quo_d      = '0;
    end else if (go_div) begin
      status_d   = STAT_OK;
      have_res_d = 1'b1;
      step_d     = S_SKIP;
      quo_d      = crop_q[1];
      rem_d      = '0;
      dcnt_d     = '0;
      state_d    = ST_DIV;
    end else if (rd_new) begin
      step_d  = rd.step;
      rd_ue_d = rd.ue;
      code_d  = '0;
      if (rd.ue) begin
        suffix_d    = 1'b0;
        lead_d      = '0;
        bits_left_d = '0;
      end else begin
        bits_left_d = rd.n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= S_HDR;
      zrun_q       <= '0;
      shift_q      <= '0;
      bcnt_q       <= '0;
      last_q       <= 1'b0;
      rd_ue_q      <= 1'b0;
      suffix_q     <= 1'b0;
      bits_left_q  <= 6'd8;
      lead_q       <= '0;
      code_q       <= '0;
      loop_q       <= '0;
      sc0_q        <= ScaleInit;
      sc1_q        <= ScaleInit;
      list_q       <= '0;
      prof_q       <= '0;
      lvl_q        <= '0;
      chroma_q     <= '0;
      fmo_q        <= 1'b0;
      wid_q        <= '0;
      hgt_q        <= '0;
      nref_q       <= '0;
      crop_q[0]    <= '0;
      crop_q[1]    <= '0;
      crop_q[2]    <= '0;
      crop_q[3]    <= '0;
      have_res_q   <= 1'b0;
      status_q     <= STAT_OK;
      fixed_q      <= 1'b0;
      rem_q        <= '0;
      quo_q        <= '0;
      dcnt_q       <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_prof_q   <= '0;
      out_lvl_q    <= '0;
      out_chroma_q <= '0;
      out_wid_q    <= '0;
      out_hgt_q    <= '0;
      out_rate_q   <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      zrun_q      <= zrun_d;
      shift_q     <= shift_d;
      bcnt_q      <= bcnt_d;
      last_q      <= last_d;
      rd_ue_q     <= rd_ue_d;
      suffix_q    <= suffix_d;
      bits_left_q <= bits_left_d;
      lead_q      <= lead_d;
      code_q      <= code_d;
      loop_q      <= loop_d;
      sc0_q       <= sc0_d;
      sc1_q       <= sc1_d;
      list_q      <= list_d;
      prof_q      <= prof_d;
      lvl_q       <= lvl_d;
      chroma_q    <= chroma_d;
      fmo_q       <= fmo_d;
      wid_q       <= wid_d;
      hgt_q       <= hgt_d;
      nref_q      <= nref_d;
      crop_q      <= crop_d;
      have_res_q  <= have_res_d;
      status_q    <= status_d;
      fixed_q     <= fixed_d;
      rem_q       <= rem_d;
      quo_q       <= quo_d;
      dcnt_q      <= dcnt_d;
      if (load_out) begin
        // error results carry zero fields
        out_valid_q  <= 1'b1;
        out_status_q <= status_q;
        if (status_q == STAT_OK) begin
          out_prof_q   <= prof_q;
          out_lvl_q    <= lvl_q;
          out_chroma_q <= (chroma_q > 8'd3) ? 2'd3 : chroma_q[1:0];
          out_wid_q    <= wid_q[DimW-1:0];
          out_hgt_q    <= hgt_q[DimW-1:0];
          out_rate_q   <= quo_q;
        end else begin
          out_prof_q   <= '0;
          out_lvl_q    <= '0;
          out_chroma_q <= '0;
          out_wid_q    <= '0;
          out_hgt_q    <= '0;
          out_rate_q   <= '0;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_i.ready          = (state_q == ST_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.profile       = out_prof_q;
  assign out_o.level         = out_lvl_q;
  assign out_o.chroma_format = out_chroma_q;
  assign out_o.frame_width   = out_wid_q;
  assign out_o.frame_height  = out_hgt_q;
  assign out_o.frame_rate    = out_rate_q;

  // divider only runs with a nonzero divisor and after the parse is closed
  a_div_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> crop_q[0] != '0 && step_q == S_SKIP && have_res_q)
    else $error("divider running without a closed parse");

  // a new result word only comes from the send state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_SEND)
    else $error("result word without send");

  // leading zero count never passes the limit by more than one
  a_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, lead_q} <= (LzW+1)'(MAX_LEAD_ZEROS + 1)))
    else $error("exp-Golomb prefix overran");

  // every accepted word is followed by bit processing or a dropped-byte wrap-up
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == ST_BITS || state_q == ST_END)
    else $error("accepted word not processed");

endmodule
